// File: hw/rtl/stg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stg_pkg: shared types and constants of the sine tone generator
// Widths, register indexes, the queue entry type and the quarter-wave table.
// ----------------------------------------------------------------------------
package stg_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int SAMPLE_BITS     = 16;

    localparam int TABLE_SIZE = 1 << TABLE_ADDR_BITS;
    localparam int MAG_BITS   = SAMPLE_BITS - 1;      // table magnitude width
    localparam int AMP_BITS   = 16;                   // Q1.15 gain
    localparam int INC_BITS   = 32;
    localparam int CFG_BITS   = 32;                   // widest register
    localparam int CFG_IDX_BITS = 1;

    localparam logic [INC_BITS-1:0] INC_RESET = INC_BITS'(39370534);
    localparam logic [AMP_BITS-1:0] AMP_RESET = AMP_BITS'(16384);

    localparam int QUEUE_DEPTH = 4;                   // power of two
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PHASE_INC = 1'b0,
        REG_AMPLITUDE = 1'b1
    } t_cfg_reg;

    // One classified tick: table address, sign half and period mark.
    typedef struct packed {
        logic                       neg;
        logic [TABLE_ADDR_BITS-1:0] idx;
        logic                       last;
    } t_tick;

    typedef logic [MAG_BITS-1:0] t_rom [TABLE_SIZE];

    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam logic [63:0] HALF_Q30 = 64'd1 << 29;
    localparam logic [63:0] POS_MAX  = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    // Taylor divisors (2n)(2n+1) for n = 1..8
    localparam logic [63:0] TAYLOR_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // Quarter-wave table at midpoint angles, integer Taylor series in Q30.
    // Evaluated once at elaboration.
    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        int          k;
        int          n;
        for (k = 0; k < TABLE_SIZE; k++) begin
            x    = (PI_Q30 * 64'(2 * k + 1)) >> (TABLE_ADDR_BITS + 2);
            term = x;
            sum  = x;
            for (n = 0; n < 8; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / TAYLOR_DIV[n];
                if (n % 2 == 0) begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end else begin
                    sum = sum + term;
                end
            end
            rom[k] = MAG_BITS'((sum * POS_MAX + HALF_Q30) >> 30);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

endpackage

// File: hw/rtl/stg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stg_front: phase accumulator and tick classifier
// Takes a tick, splits the current phase into sign and table address, steps.
// ----------------------------------------------------------------------------
module stg_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_period_end,
    input  logic [stg_pkg::INC_BITS-1:0]  i_phase_inc,
    input  logic                          i_q_full,
    output logic                          o_push,
    output stg_pkg::t_tick                o_tick
);
    import stg_pkg::*;

    logic [PHASE_BITS-1:0]      r_phase;
    logic [PHASE_BITS-1:0]      n_phase;
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-1:0] raw_idx;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    assign quad    = r_phase[PHASE_BITS-1 -: 2];
    assign raw_idx = r_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];

    // odd quadrants run the table backwards: M-1-i is the bitwise inverse
    assign o_tick.neg  = quad[1];
    assign o_tick.idx  = quad[0] ? ~raw_idx : raw_idx;
    assign o_tick.last = i_period_end;

    assign n_phase = r_phase + PHASE_BITS'(i_phase_inc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (o_push) begin
            r_phase <= n_phase;
        end
    end

endmodule

// File: hw/rtl/stg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stg_queue: short FIFO between front and back
// Small register FIFO of classified ticks, first-word fall-through.
// ----------------------------------------------------------------------------
module stg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  stg_pkg::t_tick  i_wdata,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output stg_pkg::t_tick  o_rdata
);
    import stg_pkg::*;

    t_tick                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic                 do_pop;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_BITS'(i_push) - QCNT_BITS'(do_pop);
        end
    end

endmodule

// File: hw/rtl/stg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stg_back: table lookup, gain, rounding and saturation
// Three stages: registered table read, multiply, round/saturate into output.
// ----------------------------------------------------------------------------
module stg_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  stg_pkg::t_tick                       i_q_data,
    output logic                                 o_pop,
    input  logic [stg_pkg::AMP_BITS-1:0]         i_amplitude,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [stg_pkg::SAMPLE_BITS-1:0] o_sample,
    output logic                                 o_last
);
    import stg_pkg::*;

    localparam int PROD_BITS = MAG_BITS + AMP_BITS;
    localparam int RM_BITS   = PROD_BITS + 1 - 15;
    localparam logic [RM_BITS-1:0] POS_LIM = (RM_BITS'(1) << (SAMPLE_BITS - 1)) - 1'b1;
    localparam logic [RM_BITS-1:0] NEG_LIM = RM_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [PROD_BITS:0] ROUND   = (PROD_BITS + 1)'(1) << 14;

    logic                   en;
    logic                   r_v1;
    logic                   r_v2;
    logic                   r_out_vld;
    logic [MAG_BITS-1:0]    r_mag;
    logic                   r_neg1;
    logic                   r_last1;
    logic [PROD_BITS-1:0]   r_prod;
    logic                   r_neg2;
    logic                   r_last2;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_last_out;
    logic [PROD_BITS:0]     n_round;
    logic [RM_BITS-1:0]     n_mag;
    logic [RM_BITS-1:0]     n_sat;
    logic [SAMPLE_BITS-1:0] n_sample;

    // whole pipeline moves together; held while the output is not taken
    assign en    = !r_out_vld || i_ready;
    assign o_pop = i_q_valid && en;

    assign n_round = (PROD_BITS + 1)'(r_prod) + ROUND;
    assign n_mag   = n_round[PROD_BITS -: RM_BITS];

    always_comb begin
        n_sat = n_mag;
        if (r_neg2) begin
            if (n_mag > NEG_LIM) begin
                n_sat = NEG_LIM;
            end
            n_sample = SAMPLE_BITS'(RM_BITS'(0) - n_sat);
        end else begin
            if (n_mag > POS_LIM) begin
                n_sat = POS_LIM;
            end
            n_sample = SAMPLE_BITS'(n_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_v1      <= i_q_valid;
            r_v2      <= r_v1;
            r_out_vld <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag      <= SINE_ROM[i_q_data.idx];
            r_neg1     <= i_q_data.neg;
            r_last1    <= i_q_data.last;
            r_prod     <= PROD_BITS'(r_mag) * PROD_BITS'(i_amplitude);
            r_neg2     <= r_neg1;
            r_last2    <= r_last1;
            r_sample   <= n_sample;
            r_last_out <= r_last2;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_sample = r_sample;
    assign o_last   = r_last_out;

endmodule

// File: hw/rtl/sine_tone_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_tone_generator_unit: direct digital synthesis sine oscillator
// Phase accumulator NCO with quarter-wave table, Q1.15 gain, stereo output.
// ----------------------------------------------------------------------------
// Every input request is one sample tick. The sample is taken from the
// current phase, then the phase accumulator (32 bits, wraps each turn) steps
// by the phase_increment register (index 0). The sine magnitude comes from a
// 1024-entry quarter-wave table, is scaled by the Q1.15 amplitude register
// (index 1; values above 32768 are allowed and saturate), rounded and
// driven identically on both channels; period_end passes through as
// last_of_period. Throughput is one sample per clock while the output is being
// taken: the accumulator add is the only loop. An accepted tick passes through
// the queue, the registered table read, the multiply and the round/saturate
// step into the output register. A front stage classifies ticks into a
// four-entry queue, so input keeps being taken, until the queue fills, while
// a finished sample waits on the output. Write configuration only while idle.
// ----------------------------------------------------------------------------
module sine_tone_generator_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // tick requests
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_period_end,
    // sample requests
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [stg_pkg::SAMPLE_BITS-1:0] o_left_sample,
    output logic signed [stg_pkg::SAMPLE_BITS-1:0] o_right_sample,
    output logic                                   o_last_of_period,
    // configuration writes
    input  logic                                   i_cfg_we,
    input  logic [stg_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [stg_pkg::CFG_BITS-1:0]           i_cfg_data
);
    import stg_pkg::*;

    logic [INC_BITS-1:0]           r_phase_inc;
    logic [AMP_BITS-1:0]           r_amplitude;

    logic                          q_full;
    logic                          q_push;
    logic                          q_valid;
    logic                          q_pop;
    t_tick                         q_wdata;
    t_tick                         q_rdata;
    logic signed [SAMPLE_BITS-1:0] sample;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= INC_RESET;
            r_amplitude <= AMP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PHASE_INC: r_phase_inc <= INC_BITS'(i_cfg_data);
                REG_AMPLITUDE: r_amplitude <= AMP_BITS'(i_cfg_data);
            endcase
        end
    end

    // front: accept and classify ticks
    stg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_period_end (i_period_end),
        .i_phase_inc  (r_phase_inc),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_tick       (q_wdata)
    );

    // decoupling queue
    stg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_rdata (q_rdata)
    );

    // back: table, gain, saturation, output register
    stg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_rdata),
        .o_pop       (q_pop),
        .i_amplitude (r_amplitude),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_sample    (sample),
        .o_last      (o_last_of_period)
    );

    // same sample on both channels
    assign o_left_sample  = sample;
    assign o_right_sample = sample;

    // an accepted tick is in the queue on the next cycle
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> q_valid)
        else $error("accepted tick missing from queue");

    // a stalled output must freeze the back end and keep the queue
    a_stall_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !q_pop)
        else $error("queue popped while output stalled");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("push into full queue");

endmodule
